// File: hdl/whp_pkg.sv
package whp_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam logic [31:0] RateReset = 32'd8000;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] TAG_FACT = 32'h7463_6166;
  localparam logic [31:0] MIN_FMT_SIZE = 32'd16;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_SHORT     = 4'd1,
    ST_NO_RIFF   = 4'd2,
    ST_NO_WAVE   = 4'd3,
    ST_NO_FMT    = 4'd4,
    ST_SMALL_FMT = 4'd5,
    ST_NOT_PCM   = 4'd6,
    ST_NOT_MONO  = 4'd7,
    ST_BAD_RATE  = 4'd8,
    ST_NOT_16BIT = 4'd9,
    ST_UNKNOWN   = 4'd10
  } status_t;

  // one classified byte, as queued between front and parser
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        sof;
    logic        eof;
    logic [31:0] pos;
  } whp_entry_t;

endpackage

// File: hdl/whp_front.sv
module whp_front import whp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_start_of_file,
  input  logic       in_end_of_file,
  input  logic       q_full,
  output logic       q_push,
  output whp_entry_t q_entry
);

  logic [31:0] pos_r;
  logic [31:0] pos_nxt;

  // position of this byte counted from 1 at the start of the file; wraps
  assign pos_nxt = in_start_of_file ? 32'd1 : pos_r + 32'd1;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  assign q_entry.data_byte = in_data_byte;
  assign q_entry.sof       = in_start_of_file;
  assign q_entry.eof       = in_end_of_file;
  assign q_entry.pos       = pos_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 32'd0;
    end else if (q_push) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// File: hdl/whp_queue.sv
module whp_queue import whp_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  whp_entry_t wr_entry,
  input  logic       pop,
  output whp_entry_t rd_entry,
  output logic       full,
  output logic       empty
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  whp_entry_t          slots_r [Depth];
  logic [PtrW-1:0]     wr_ptr_r;
  logic [PtrW-1:0]     rd_ptr_r;
  logic [CntW-1:0]     cnt_r;

  assign full     = (cnt_r == CntW'(Depth));
  assign empty    = (cnt_r == '0);
  assign rd_entry = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> cnt_r < CntW'(Depth))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("queue underflow");
`endif

endmodule

// File: hdl/whp_parser.sv
module whp_parser import whp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  whp_entry_t  q_entry,
  output logic        q_pop,
  input  logic [31:0] rate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [31:0] out_data_length,
  output logic [31:0] out_data_offset
);

  typedef enum logic [3:0] {
    PH_RIFF, PH_RSIZE, PH_WAVE, PH_FMT, PH_HSIZE, PH_FORMAT, PH_CHANS, PH_RATE,
    PH_BYSEC, PH_BYSAM, PH_BISAM, PH_SKIPFMT, PH_CTAG, PH_CLEN, PH_SKIPFACT
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  bif_r, bif_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic        mis_r, mis_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic        fin_r, fin_nxt;

  logic        out_valid_r;
  logic [3:0]  out_status_r;
  logic [31:0] out_len_r;
  logic [31:0] out_off_r;

  logic        res_fire;
  status_t     res_status;
  logic [31:0] res_len;

  assign q_pop = !q_empty && (!out_valid_r || !out_stall);

  always_comb begin
    phase_t      phase_c;
    logic [1:0]  bif_c;
    logic [31:0] shift_c;
    logic        mis_c;
    logic [31:0] skip_c;
    logic [31:0] tag_c;
    logic        fin_c;
    logic [31:0] v;
    logic        len4;
    logic        last;
    logic        decided;
    status_t     st;

    phase_nxt  = phase_r;
    bif_nxt    = bif_r;
    shift_nxt  = shift_r;
    mis_nxt    = mis_r;
    skip_nxt   = skip_r;
    tag_nxt    = tag_r;
    fin_nxt    = fin_r;
    res_fire   = 1'b0;
    res_status = ST_SHORT;
    res_len    = 32'd0;
    decided    = 1'b0;
    st         = ST_SHORT;

    if (q_entry.sof) begin
      phase_c = PH_RIFF;
      bif_c   = 2'd0;
      shift_c = 32'd0;
      mis_c   = 1'b0;
      skip_c  = 32'd0;
      tag_c   = 32'd0;
      fin_c   = 1'b0;
    end else begin
      phase_c = phase_r;
      bif_c   = bif_r;
      shift_c = shift_r;
      mis_c   = mis_r;
      skip_c  = skip_r;
      tag_c   = tag_r;
      fin_c   = fin_r;
    end

    v    = shift_c | ({24'd0, q_entry.data_byte} << {bif_c, 3'b000});
    len4 = !(phase_c == PH_FORMAT || phase_c == PH_CHANS ||
             phase_c == PH_BYSAM || phase_c == PH_BISAM);
    last = len4 ? (bif_c == 2'd3) : (bif_c == 2'd1);

    if (q_pop) begin
      phase_nxt = phase_c;
      bif_nxt   = bif_c;
      shift_nxt = shift_c;
      mis_nxt   = mis_c;
      skip_nxt  = skip_c;
      tag_nxt   = tag_c;
      fin_nxt   = fin_c;
      if (!fin_c) begin
        if (phase_c == PH_SKIPFMT || phase_c == PH_SKIPFACT) begin
          skip_nxt = skip_c - 32'd1;
          if (skip_c == 32'd1) begin
            phase_nxt = PH_CTAG;
          end
        end else if (!last) begin
          shift_nxt = v;
          bif_nxt   = bif_c + 2'd1;
        end else begin
          shift_nxt = 32'd0;
          bif_nxt   = 2'd0;
          unique case (phase_c)
            PH_RIFF: begin
              mis_nxt   = (v != TAG_RIFF);
              phase_nxt = PH_RSIZE;
            end
            PH_RSIZE: phase_nxt = PH_WAVE;
            PH_WAVE: begin
              if (mis_c) begin
                decided = 1'b1;
                st      = ST_NO_RIFF;
              end else if (v != TAG_WAVE) begin
                decided = 1'b1;
                st      = ST_NO_WAVE;
              end else begin
                phase_nxt = PH_FMT;
              end
            end
            PH_FMT: begin
              if (v != TAG_FMT) begin
                decided = 1'b1;
                st      = ST_NO_FMT;
              end else begin
                phase_nxt = PH_HSIZE;
              end
            end
            PH_HSIZE: begin
              if (v < MIN_FMT_SIZE || v[31]) begin
                decided = 1'b1;
                st      = ST_SMALL_FMT;
              end else begin
                // keep only the excess beyond the fixed part of the format block
                skip_nxt  = v - MIN_FMT_SIZE;
                phase_nxt = PH_FORMAT;
              end
            end
            PH_FORMAT: begin
              if (v != 32'd1) begin
                decided = 1'b1;
                st      = ST_NOT_PCM;
              end else begin
                phase_nxt = PH_CHANS;
              end
            end
            PH_CHANS: begin
              if (v != 32'd1) begin
                decided = 1'b1;
                st      = ST_NOT_MONO;
              end else begin
                phase_nxt = PH_RATE;
              end
            end
            PH_RATE: begin
              if (v != rate) begin
                decided = 1'b1;
                st      = ST_BAD_RATE;
              end else begin
                phase_nxt = PH_BYSEC;
              end
            end
            PH_BYSEC: phase_nxt = PH_BYSAM;
            PH_BYSAM: begin
              if (v != 32'd2) begin
                decided = 1'b1;
                st      = ST_NOT_16BIT;
              end else begin
                phase_nxt = PH_BISAM;
              end
            end
            PH_BISAM: phase_nxt = (skip_c == 32'd0) ? PH_CTAG : PH_SKIPFMT;
            PH_CTAG: begin
              tag_nxt   = v;
              phase_nxt = PH_CLEN;
            end
            PH_CLEN: begin
              if (tag_c == TAG_DATA) begin
                skip_nxt = v;
                decided  = 1'b1;
                st       = ST_OK;
                res_len  = v;
              end else if (tag_c != TAG_FACT) begin
                decided = 1'b1;
                st      = ST_UNKNOWN;
              end else begin
                skip_nxt  = v;
                phase_nxt = (v == 32'd0) ? PH_CTAG : PH_SKIPFACT;
              end
            end
            default: phase_nxt = phase_c;
          endcase
        end
        if (decided || q_entry.eof) begin
          res_fire   = 1'b1;
          res_status = decided ? st : ST_SHORT;
          fin_nxt    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_RIFF;
      bif_r       <= 2'd0;
      shift_r     <= 32'd0;
      mis_r       <= 1'b0;
      skip_r      <= 32'd0;
      tag_r       <= 32'd0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      bif_r   <= bif_nxt;
      shift_r <= shift_nxt;
      mis_r   <= mis_nxt;
      skip_r  <= skip_nxt;
      tag_r   <= tag_nxt;
      fin_r   <= fin_nxt;
      if (res_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_status_r <= res_status;
      out_len_r    <= (res_status == ST_OK) ? res_len : 32'd0;
      out_off_r    <= (res_status == ST_OK) ? q_entry.pos : 32'd0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_data_length = out_len_r;
  assign out_data_offset = out_off_r;

`ifndef SYNTH
  a_ok_only_at_length: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire && res_status == ST_OK |-> phase_r == PH_CLEN && !q_entry.sof)
    else $error("ok status outside chunk length field");

  a_one_result_per_file: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && fin_r && !q_entry.sof |-> !res_fire)
    else $error("second result for one file");
`endif

endmodule

// File: hdl/wav_header_parser_core.sv
// WAV header parser core.
// Input channel (in_valid / in_stall): one file byte per transfer, with
// in_start_of_file on byte 0 of a file and in_end_of_file on its last byte.
// Output channel (out_valid / out_stall): one result per file, status plus
// data length and offset of the first sample (both zero unless status is ok).
// Later bytes of a finished file are dropped until the next start mark.
// Config channel (cfg_valid / cfg_ready): cfg_ready is always high; writes
// the expected sample rate. The user writes only while no file is in flight;
// the block does not enforce it. Throughput: one byte per cycle while out_stall
// does not hold the parser. With no stall, the deciding byte is written into
// the queue, then the parser step that pops it loads the output register.
// A full output register with out_stall high holds the parser; the byte
// queue (QueueDepth entries) then fills and raises in_stall.
// Reset (rst_n low, synchronous): queue empty, parser expects byte 0 of a
// file, sample rate back to 8000.
module wav_header_parser_core import whp_pkg::*; #(
  parameter int unsigned QueueDepth = whp_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_file,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [31:0] out_data_length,
  output logic [31:0] out_data_offset,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_expected_sample_rate
);

  logic        rate_wr;
  logic [31:0] rate_val_r;
  logic        q_full;
  logic        q_empty;
  logic        q_push;
  logic        q_pop;
  whp_entry_t  q_wr;
  whp_entry_t  q_rd;

  assign cfg_ready = 1'b1;
  assign rate_wr   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_val_r <= RateReset;
    end else if (rate_wr) begin
      rate_val_r <= cfg_expected_sample_rate;
    end
  end

  whp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_start_of_file (in_start_of_file),
    .in_end_of_file   (in_end_of_file),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_entry          (q_wr)
  );

  whp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr),
    .pop      (q_pop),
    .rd_entry (q_rd),
    .full     (q_full),
    .empty    (q_empty)
  );

  whp_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_entry         (q_rd),
    .q_pop           (q_pop),
    .rate            (rate_val_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_data_length (out_data_length),
    .out_data_offset (out_data_offset)
  );

endmodule
